/* rtl/core/pdx_pkg.sv */
// Shared types, register codes, AES tables and round functions for the payload decryptor.
package pdx_pkg;

    typedef logic [15:0][7:0] t_block;   // byte i of a block sits at index i
    typedef logic [3:0][31:0] t_words;   // four round-key words, word c at index c

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned KEY_WORDS   = 44;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd2;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd3;

    localparam logic [1:0] MODE_XOR = 2'd1;
    localparam logic [1:0] MODE_AES = 2'd2;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // GF(2^8) multiply by a 4-bit constant
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] x2, x4, x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        return (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^
               (m[2] ? x4 : 8'h00) ^ (m[3] ? x8 : 8'h00);
    endfunction

    // RotWord then SubWord
    function automatic logic [31:0] rot_sub(input logic [31:0] w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    function automatic t_block inv_shift_sub(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[4*c+j] = INV_SBOX[s[4*((c + 4 - j) & 3) + j]];
            end
        end
        return t;
    endfunction

    function automatic t_block add_rk(input t_block s, input t_words rk);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[4*c+j] = s[4*c+j] ^ rk[c][31-8*j -: 8];
            end
        end
        return t;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            t[4*c]   = gm(s[4*c], 4'd14) ^ gm(s[4*c+1], 4'd11) ^
                       gm(s[4*c+2], 4'd13) ^ gm(s[4*c+3], 4'd9);
            t[4*c+1] = gm(s[4*c], 4'd9) ^ gm(s[4*c+1], 4'd14) ^
                       gm(s[4*c+2], 4'd11) ^ gm(s[4*c+3], 4'd13);
            t[4*c+2] = gm(s[4*c], 4'd13) ^ gm(s[4*c+1], 4'd9) ^
                       gm(s[4*c+2], 4'd14) ^ gm(s[4*c+3], 4'd11);
            t[4*c+3] = gm(s[4*c], 4'd11) ^ gm(s[4*c+1], 4'd13) ^
                       gm(s[4*c+2], 4'd9) ^ gm(s[4*c+3], 4'd14);
        end
        return t;
    endfunction

endpackage

/* rtl/core/pdx_ram.sv */
// Generic simple dual-port RAM with registered read.
module pdx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

/* rtl/core/pdx_aes.sv */
// Iterative AES-128 decryption unit: key expansion into a word RAM, then one round per pass.
module pdx_aes import pdx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_block     i_key,
    input  logic       i_load,
    input  logic [7:0] i_load_byte,
    input  logic       i_start,
    output logic       o_done,
    output t_block     o_block
);
    typedef enum logic [1:0] {S_IDLE, S_KEXP, S_RND} t_state;

    t_state      r_state;
    logic [5:0]  r_idx;
    t_words      r_win;
    logic [7:0]  r_rcon;
    logic [3:0]  r_rnd;
    logic [2:0]  r_ph;
    t_words      r_rk;
    t_block      r_s;
    logic        r_done;

    logic [31:0] w_kw, w_t, w_new, w_rdata;
    logic        w_re;
    logic [5:0]  w_raddr;
    t_words      w_rk;
    t_block      w_x;

    // initial words straight from the padded key, big-endian
    assign w_kw = {i_key[{r_idx[1:0], 2'd0}], i_key[{r_idx[1:0], 2'd1}],
                   i_key[{r_idx[1:0], 2'd2}], i_key[{r_idx[1:0], 2'd3}]};
    assign w_t  = (r_idx[1:0] == 2'd0) ? (rot_sub(r_win[3]) ^ {r_rcon, 24'd0}) : r_win[3];
    assign w_new = (r_idx < 6'd4) ? w_kw : (r_win[0] ^ w_t);

    assign w_re    = (r_state == S_RND) && (r_ph < 3'd4);
    assign w_raddr = {r_rnd, 2'b00} + {3'd0, r_ph};
    assign w_rk    = {w_rdata, r_rk[2:0]};
    assign w_x     = add_rk(r_s, w_rk);

    pdx_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_KEXP),
        .i_waddr (r_idx),
        .i_wdata (w_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_load) begin
                        r_s <= {i_load_byte, r_s[15:1]};
                    end
                    if (i_start) begin
                        r_state <= S_KEXP;
                        r_idx   <= 6'd0;
                        r_rcon  <= 8'h01;
                    end
                end
                S_KEXP: begin
                    r_win <= {w_new, r_win[3:1]};
                    if (r_idx[1:0] == 2'd0 && r_idx >= 6'd4) begin
                        r_rcon <= xt(r_rcon);
                    end
                    if (r_idx == 6'(KEY_WORDS - 1)) begin
                        r_state <= S_RND;
                        r_rnd   <= 4'd10;
                        r_ph    <= 3'd0;
                    end else begin
                        r_idx <= r_idx + 6'd1;
                    end
                end
                S_RND: begin
                    if (r_ph != 3'd0 && r_ph != 3'd4) begin
                        r_rk[r_ph[1:0] - 2'd1] <= w_rdata;
                    end
                    if (r_ph == 3'd0 && r_rnd != 4'd10) begin
                        r_s <= inv_shift_sub(r_s);
                    end
                    if (r_ph == 3'd4) begin
                        r_s <= (r_rnd != 4'd0 && r_rnd != 4'd10) ? inv_mix(w_x) : w_x;
                        r_ph <= 3'd0;
                        if (r_rnd == 4'd0) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_rnd <= r_rnd - 4'd1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_block = r_s;
endmodule

/* rtl/core/payload_decryptor_xor_aes.sv */
// Payload decryptor top level: byte channel, block store, XOR path and AES unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one ciphertext byte with a
//   buffer-end flag; output channel (o_out_valid / i_out_stall) carries plain
//   bytes with buffer_done on the buffer's final byte and run_last on the last
//   result that one input byte caused. Configuration is written through
//   i_cfg_valid / o_cfg_ready (always ready) while the block is idle.
//   Mode none or XOR: a byte passes accept, store check and output load, with
//   a block RAM read and an output load for each byte left gathered from AES
//   mode before its own load; a lone byte goes from acceptance through T_EMIT_RD
//   and T_EMIT_CUR to the output register. XOR runs over key byte position mod
//   key length. AES mode: bytes are written into a 16-entry block RAM, input
//   staying open until the block fills or the buffer ends. The sixteenth byte
//   starts a load into the AES unit, a key expansion of 44 words into the
//   round-key RAM and 11 rounds, each with four round-key RAM reads, then the
//   done handoff and the 16 result bytes, each loaded when the output register
//   is free. A partial block at buffer end, or any block with key length zero,
//   comes out unchanged straight from the block RAM. Reset clears configuration
//   to its defaults, the fill count and the XOR position; the RAMs need no
//   clearing. A stalled receiver holds the output register and the emit
//   sequencer waits; input stays stalled until done.
module payload_decryptor_xor_aes import pdx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_plain_byte,
    output logic        o_buffer_done,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    typedef enum logic [2:0] {
        T_IDLE, T_EMIT_RD, T_EMIT_WAIT, T_EMIT_CUR, T_LOAD, T_AES, T_EMIT_AES
    } t_state;

    t_state      r_state;
    logic [1:0]  r_mode;
    logic [63:0] r_key_lo, r_key_hi;
    logic [4:0]  r_key_len;
    logic [3:0]  r_fill;
    logic [3:0]  r_xpos;
    logic [4:0]  r_cnt;      // gathered bytes to emit from the block RAM
    logic [4:0]  r_e;        // emit / load index
    logic [7:0]  r_cur;      // current byte, already XORed when XOR is on
    logic        r_end;
    logic        r_emit_cur;
    logic        r_out_valid;
    logic [7:0]  r_plain;
    logic        r_done;
    logic        r_last;

    logic [4:0]   w_n;
    logic [127:0] w_key_all;
    t_block       w_key;
    logic         w_accept, w_slot, w_xor_on, w_emit;
    logic [3:0]   w_p;
    logic [4:0]   w_np, w_nfill;
    logic         w_st_re;
    logic [7:0]   w_st_rdata;
    logic         w_aes_done;
    t_block       w_aes_block;

    // effective key length and zero-padded key
    assign w_n       = (r_key_len > 5'd16) ? 5'd16 : r_key_len;
    assign w_key_all = {r_key_hi, r_key_lo};
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < w_n) begin
                w_key[i] = w_key_all[8*i +: 8];
            end else begin
                w_key[i] = 8'h00;
            end
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_slot   = !r_out_valid || !i_out_stall;
    // output register takes a new item this cycle
    assign w_emit   = w_slot && ((r_state == T_EMIT_WAIT) || (r_state == T_EMIT_CUR) ||
                                 (r_state == T_EMIT_AES));
    assign w_xor_on = (r_mode == MODE_XOR) && (w_n != 5'd0);
    // stale position at or beyond the key length restarts at zero
    assign w_p      = ({1'b0, r_xpos} >= w_n) ? 4'd0 : r_xpos;
    assign w_np     = {1'b0, w_p} + 5'd1;
    assign w_nfill  = {1'b0, r_fill} + 5'd1;

    assign w_st_re = ((r_state == T_EMIT_RD) && (r_e != r_cnt)) ||
                     ((r_state == T_LOAD) && !r_e[4]);

    pdx_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && r_mode == MODE_AES),
        .i_waddr (r_fill),
        .i_wdata (i_data_byte),
        .i_re    (w_st_re),
        .i_raddr (r_e[3:0]),
        .o_rdata (w_st_rdata)
    );

    pdx_aes u_aes (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (w_key),
        .i_load      (r_state == T_LOAD && r_e != 5'd0),
        .i_load_byte (w_st_rdata),
        .i_start     (r_state == T_LOAD && r_e[4]),
        .o_done      (w_aes_done),
        .o_block     (w_aes_block)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_mode      <= 2'd0;
            r_key_lo    <= 64'd0;
            r_key_hi    <= 64'd0;
            r_key_len   <= 5'd16;
            r_fill      <= 4'd0;
            r_xpos      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:     r_mode    <= i_cfg_data[1:0];
                    CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                    CFG_KEY_LEN:  r_key_len <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_end <= i_buffer_end;
                        r_e   <= 5'd0;
                        if (i_buffer_end) begin
                            r_xpos <= 4'd0;
                        end
                        if (r_mode == MODE_AES) begin
                            r_emit_cur <= 1'b0;
                            if (w_nfill[4]) begin
                                r_fill <= 4'd0;
                                r_cnt  <= 5'd16;
                                r_state <= (w_n != 5'd0) ? T_LOAD : T_EMIT_RD;
                            end else if (i_buffer_end) begin
                                r_fill  <= 4'd0;
                                r_cnt   <= w_nfill;
                                r_state <= T_EMIT_RD;
                            end else begin
                                r_fill <= w_nfill[3:0];
                            end
                        end else begin
                            r_emit_cur <= 1'b1;
                            r_cnt      <= {1'b0, r_fill};
                            r_fill     <= 4'd0;
                            r_state    <= T_EMIT_RD;
                            if (w_xor_on) begin
                                r_cur <= i_data_byte ^ w_key[w_p];
                                if (!i_buffer_end) begin
                                    r_xpos <= (w_np >= w_n) ? 4'd0 : w_np[3:0];
                                end
                            end else begin
                                r_cur <= i_data_byte;
                            end
                        end
                    end
                end
                T_EMIT_RD: begin
                    if (r_e == r_cnt) begin
                        r_state <= r_emit_cur ? T_EMIT_CUR : T_IDLE;
                    end else begin
                        r_state <= T_EMIT_WAIT;
                    end
                end
                T_EMIT_WAIT: begin
                    if (w_slot) begin
                        r_plain     <= w_st_rdata;
                        r_last      <= (r_e == r_cnt - 5'd1) && !r_emit_cur;
                        r_done      <= (r_e == r_cnt - 5'd1) && !r_emit_cur && r_end;
                        r_e         <= r_e + 5'd1;
                        r_state     <= T_EMIT_RD;
                    end
                end
                T_EMIT_CUR: begin
                    if (w_slot) begin
                        r_plain     <= r_cur;
                        r_last      <= 1'b1;
                        r_done      <= r_end;
                        r_state     <= T_IDLE;
                    end
                end
                T_LOAD: begin
                    if (r_e[4]) begin
                        r_state <= T_AES;
                    end else begin
                        r_e <= r_e + 5'd1;
                    end
                end
                T_AES: begin
                    if (w_aes_done) begin
                        r_e     <= 5'd0;
                        r_state <= T_EMIT_AES;
                    end
                end
                T_EMIT_AES: begin
                    if (w_slot) begin
                        r_plain     <= w_aes_block[r_e[3:0]];
                        r_last      <= (r_e[3:0] == 4'd15);
                        r_done      <= (r_e[3:0] == 4'd15) && r_end;
                        r_e         <= r_e + 5'd1;
                        if (r_e[3:0] == 4'd15) begin
                            r_state <= T_IDLE;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != T_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_plain_byte  = r_plain;
    assign o_buffer_done = r_done;
    assign o_run_last    = r_last;
    assign o_cfg_ready   = 1'b1;
endmodule

/* dv/pdx_checker.sv */
// Scoreboard for the payload decryptor: watches both byte channels and the register port.
module pdx_checker import pdx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_plain_byte,
    input  logic        i_buffer_done,
    input  logic        i_run_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] plain;
        logic       done;
        logic       last;
    } t_plain_item;

    t_plain_item plain_q[$];
    logic [7:0]  inv_box [256];

    // shadow copy of the block's registers and state
    logic [1:0]  mode;
    logic [63:0] key_lo, key_hi;
    logic [4:0]  key_len;
    t_block      gathered;
    int          fill;
    int          xor_pos;

    initial begin
        for (int i = 0; i < 256; i++) begin
            inv_box[SBOX[i]] = i[7:0];
        end
    end

    function automatic logic [7:0] key_at(input int i);
        return (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
    endfunction

    function automatic int key_used();
        return (key_len > 5'd16) ? 16 : int'(key_len);
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input int m);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
            if (m[k]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    function automatic t_block unshift_sub(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[4*c+j] = inv_box[s[4*((c + 4 - j) % 4) + j]];
        return t;
    endfunction

    function automatic t_block mix_key(input t_block s, input logic [31:0] w [44], input int r);
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                s[4*c+j] ^= w[4*r+c][31-8*j -: 8];
        return s;
    endfunction

    function automatic t_block aes_decrypt(input t_block s);
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [7:0]  a0, a1, a2, a3;
        int          n;
        n = key_used();
        for (int i = 0; i < 4; i++) begin
            w[i] = '0;
            for (int j = 0; j < 4; j++)
                if (4*i + j < n) w[i][31-8*j -: 8] = key_at(4*i + j);
        end
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        s = mix_key(s, w, 10);
        for (int r = 9; r >= 1; r--) begin
            s = mix_key(unshift_sub(s), w, r);
            for (int c = 0; c < 4; c++) begin
                a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
            end
        end
        return mix_key(unshift_sub(s), w, 0);
    endfunction

    // expected plain bytes for one accepted ciphertext byte
    task automatic predict_plain(input logic [7:0] b, input logic last_in_buf);
        t_plain_item run[$];
        int          n;
        int          p;
        n = key_used();
        if (mode == MODE_AES) begin
            gathered[fill] = b;
            fill++;
            if (fill == BLOCK_BYTES) begin
                if (n != 0) gathered = aes_decrypt(gathered);
                for (int i = 0; i < BLOCK_BYTES; i++) run.push_back('{gathered[i], 1'b0, 1'b0});
                fill = 0;
            end else if (last_in_buf) begin
                for (int i = 0; i < fill; i++) run.push_back('{gathered[i], 1'b0, 1'b0});
                fill = 0;
            end
        end else begin
            // bytes left over from AES mode go out unchanged first
            for (int i = 0; i < fill; i++) run.push_back('{gathered[i], 1'b0, 1'b0});
            fill = 0;
            if (mode == MODE_XOR && n != 0) begin
                p = (xor_pos >= n) ? 0 : xor_pos;
                b ^= key_at(p);
                p++;
                xor_pos = (p >= n) ? 0 : p;
            end
            run.push_back('{b, 1'b0, 1'b0});
        end
        if (last_in_buf) xor_pos = 0;
        if (run.size() > 0) begin
            run[run.size()-1].last = 1'b1;
            run[run.size()-1].done = last_in_buf;
        end
        foreach (run[i]) plain_q.push_back(run[i]);
    endtask

    // sampled at the falling edge: values are settled for the next rising edge
    always @(negedge i_clk) begin
        t_plain_item exp_item;
        if (!i_rst_n) begin
            mode = 2'd0;
            key_lo = '0;
            key_hi = '0;
            key_len = 5'd16;
            fill = 0;
            xor_pos = 0;
            plain_q.delete();
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:     mode = i_cfg_data[1:0];
                    CFG_KEY_LOW:  key_lo = i_cfg_data;
                    CFG_KEY_HIGH: key_hi = i_cfg_data;
                    CFG_KEY_LEN:  key_len = i_cfg_data[4:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_plain(i_data_byte, i_buffer_end);
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (plain_q.size() == 0) begin
                    $display("%0t: unexpected result plain=%h done=%b last=%b",
                             $time, i_plain_byte, i_buffer_done, i_run_last);
                    o_fail_count++;
                end else begin
                    exp_item = plain_q.pop_front();
                    if (exp_item.plain !== i_plain_byte) begin
                        $display("%0t: plain_byte expected %h actual %h",
                                 $time, exp_item.plain, i_plain_byte);
                        o_fail_count++;
                    end
                    if (exp_item.done !== i_buffer_done) begin
                        $display("%0t: buffer_done expected %b actual %b",
                                 $time, exp_item.done, i_buffer_done);
                        o_fail_count++;
                    end
                    if (exp_item.last !== i_run_last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, exp_item.last, i_run_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = plain_q.size();
    end

endmodule

/* dv/payload_decryptor_xor_aes_tb.sv */
// Testbench top: clock, reset, register writes, byte stimulus and the verdict.
module payload_decryptor_xor_aes_tb import pdx_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_plain_byte;
    logic        o_buffer_done;
    logic        o_run_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int fail_count;
    int pending;
    int result_count;

    // idle rates in percent for the current phase
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off: request count from the stimulus, served by the stall process
    int hold_req;
    int hold_seen;
    int hold_left;
    int items_sent;

    payload_decryptor_xor_aes i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_buffer_end  (i_buffer_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_plain_byte  (o_plain_byte),
        .o_buffer_done (o_buffer_done),
        .o_run_last    (o_run_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pdx_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_buffer_end   (i_buffer_end),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_plain_byte   (o_plain_byte),
        .i_buffer_done  (o_buffer_done),
        .i_run_last     (o_run_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stall per phase, or a counted long hold-off
    initial begin
        i_out_stall = 1'b0;
        hold_seen = 0;
        hold_left = 0;
    end
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #5ms;
        $display("timeout with %0d results still expected", pending);
        $display("status: fail");
        $finish;
    end

    // one register write; returns at the clock edge after the one that took it
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every expected result, then let a whole AES block's worth of cycles pass
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [4:0] len);
        drain();
        write_reg(CFG_MODE, {62'd0, m});
        write_reg(CFG_KEY_LOW, lo);
        write_reg(CFG_KEY_HIGH, hi);
        write_reg(CFG_KEY_LEN, {59'd0, len});
    endtask

    // offer one item, hold it until taken, then maybe leave a gap
    task automatic send_byte(input logic [7:0] b, input logic last_in_buf);
        logic free;
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last_in_buf;
        do begin
            @(negedge i_clk);
            free = !o_in_stall;
            @(posedge i_clk);
        end while (!free);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_buffer(input int len);
        for (int i = 0; i < len; i++) send_byte($urandom_range(255), i == len - 1);
    endtask

    task automatic set_idle(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    initial begin
        logic [1:0]  rmode;
        logic [4:0]  rlen;
        int          blen;
        int          seg_items;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = 8'h00;
        i_buffer_end = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_MODE;
        i_cfg_data   = '0;
        hold_req     = 0;
        items_sent   = 0;
        set_idle(0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pass-through at reset defaults, data extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        // XOR with a short key: position wraps, then clears at buffer end
        set_config(MODE_XOR, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd3);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h0f, 1'b0);
        send_byte(8'hf0, 1'b1);
        send_byte(8'h11, 1'b1);
        // key length zero leaves XOR bytes alone
        set_config(MODE_XOR, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd0);
        send_byte(8'h3c, 1'b1);
        // key length above sixteen acts as sixteen
        set_config(MODE_XOR, 64'h8877_6655_4433_2211, 64'h0000_0000_0000_0000, 5'd31);
        send_buffer(17);
        // unused mode code behaves as pass-through
        set_config(2'd3, 64'h0, 64'h0, 5'd16);
        send_byte(8'h80, 1'b1);
        // AES: partial block at buffer end comes out unchanged
        set_config(MODE_AES, 64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908, 5'd16);
        send_buffer(3);
        // AES: full block
        send_buffer(16);
        // bytes left gathered when the mode changes away from AES
        for (int i = 0; i < 4; i++) send_byte($urandom_range(255), 1'b0);
        drain();
        write_reg(CFG_MODE, {62'd0, 2'd0});
        send_byte(8'h7e, 1'b1);

        // random segments with fresh settings and cycling idle phases
        for (int seg = 0; seg < 8; seg++) begin
            set_idle(seg);
            rmode = (seg % 2 == 0) ? MODE_AES : 2'($urandom_range(3));
            case (seg % 4)
                0: rlen = 5'd16;
                1: rlen = 5'd0;
                2: rlen = 5'd31;
                default: rlen = 5'($urandom_range(16));
            endcase
            set_config(rmode, {$urandom, $urandom}, {$urandom, $urandom}, rlen);
            if (seg == 4) begin
                // long receiver hold-off while bytes keep coming in
                hold_req++;
                send_buffer(32);
            end
            seg_items = 0;
            while (seg_items < 8) begin
                if (rmode == MODE_AES && $urandom_range(3) != 0)
                    blen = 16 * $urandom_range(1, 2) + (($urandom_range(3) == 0) ?
                           $urandom_range(1, 15) : 0);
                else
                    blen = $urandom_range(1, 20);
                send_buffer(blen);
                seg_items += blen;
                if (seg == 2) begin
                    // sender pause until everything has come out
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end

        drain();
        $display("sent %0d bytes across none, XOR and AES modes; %0d plain bytes checked",
                 items_sent, result_count);
        $display("key lengths zero, short, sixteen and above; idle, stall and hold-off phases");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pdx_pkg.sv
rtl/core/pdx_ram.sv
rtl/core/pdx_aes.sv
rtl/core/payload_decryptor_xor_aes.sv
dv/pdx_checker.sv
dv/payload_decryptor_xor_aes_tb.sv
